// File: rtl/bgi_pkg.sv
package bgi_pkg;

  localparam int VAL_W     = 32;
  localparam int INDEX_W   = 12;
  localparam int MODE_W    = 2;
  localparam int PTS_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MONEYNESS_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATURITY_POINTS  = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_MONEYNESS = 2'd0,
    MODE_LOAD_MATURITY  = 2'd1,
    MODE_LOAD_VALUE     = 2'd2,
    MODE_QUERY          = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_LOAD_M,
    OP_LOAD_T,
    OP_LOAD_V,
    OP_QUERY,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [INDEX_W-1:0]      index;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] qm;
    logic signed [VAL_W-1:0] qt;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_END0,
    S_END1,
    S_SRD,
    S_SCMP,
    S_BRD0,
    S_BRD1,
    S_VRD,
    S_LSTART,
    S_LWAIT,
    S_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIV,
    L_MUL,
    L_ADD
  } lerp_state_t;

endpackage

// File: rtl/bgi_if.sv
interface bgi_in_if;
  import bgi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [INDEX_W-1:0]       index;
  logic signed [VAL_W-1:0]  load_value;
  logic signed [VAL_W-1:0]  query_moneyness;
  logic signed [VAL_W-1:0]  query_maturity;
  modport source (output valid, mode, index, load_value, query_moneyness, query_maturity,
                  input ready);
  modport sink (input valid, mode, index, load_value, query_moneyness, query_maturity,
                output ready);
endinterface

interface bgi_out_if;
  import bgi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] interpolated;
  logic                    out_of_range;
  modport source (output valid, interpolated, out_of_range, input ready);
  modport sink (input valid, interpolated, out_of_range, output ready);
endinterface

interface bgi_cfg_if;
  import bgi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PTS_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/bgi_front.sv
module bgi_front #(
  parameter int MAX_MONEYNESS_POINTS = 64,
  parameter int MAX_MATURITY_POINTS  = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  bgi_in_if.sink         in_ch,
  output bgi_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_pop
);
  import bgi_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  op_t        op;
  logic       push;

  always_comb begin
    case (mode_t'(in_ch.mode))
      MODE_LOAD_MONEYNESS: op = (int'(in_ch.index) < MAX_MONEYNESS_POINTS) ? OP_LOAD_M : OP_DROP;
      MODE_LOAD_MATURITY:  op = (int'(in_ch.index) < MAX_MATURITY_POINTS) ? OP_LOAD_T : OP_DROP;
      MODE_LOAD_VALUE:     op = (int'(in_ch.index) < MAX_MONEYNESS_POINTS * MAX_MATURITY_POINTS)
                                ? OP_LOAD_V : OP_DROP;
      MODE_QUERY:          op = OP_QUERY;
      default:             op = OP_DROP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && (op != OP_DROP);
  assign item        = q_r[rp_r];
  assign item_valid  = (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].op    <= op;
      q_r[wp_r].index <= in_ch.index;
      q_r[wp_r].value <= in_ch.load_value;
      q_r[wp_r].qm    <= in_ch.query_moneyness;
      q_r[wp_r].qt    <= in_ch.query_maturity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (item_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, item_pop};
    end
  end

endmodule

// File: rtl/bgi_lerp.sv
module bgi_lerp #(
  parameter int FRACTION_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [bgi_pkg::VAL_W-1:0] x0,
  input  logic signed [bgi_pkg::VAL_W-1:0] x1,
  input  logic signed [bgi_pkg::VAL_W-1:0] x,
  input  logic signed [bgi_pkg::VAL_W-1:0] y0,
  input  logic signed [bgi_pkg::VAL_W-1:0] y1,
  output logic                            done,
  output logic signed [bgi_pkg::VAL_W-1:0] result
);
  import bgi_pkg::*;

  localparam int PW = VAL_W + 1 + FRACTION_BITS + 2;
  localparam int CW = $clog2(FRACTION_BITS + 1);

  lerp_state_t             st_r, st_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [VAL_W:0]          rem_r, rem_nxt, div_r, div_nxt;
  logic [FRACTION_BITS:0]  t_r, t_nxt;
  logic signed [VAL_W:0]   dy_r, dy_nxt;
  logic signed [VAL_W-1:0] y0_r, y0_nxt;
  logic signed [PW-1:0]    prod_r, prod_nxt, sh;
  logic                    done_r, done_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;
  logic signed [VAL_W:0]   w, d;
  logic [VAL_W:0]          wmag, dmag;
  logic [VAL_W+1:0]        r2, r2sub;
  logic                    ge;

  assign w     = {x1[VAL_W-1], x1} - {x0[VAL_W-1], x0};
  assign d     = {x[VAL_W-1], x} - {x0[VAL_W-1], x0};
  assign wmag  = w[VAL_W] ? (VAL_W+1)'(-w) : (VAL_W+1)'(w);
  assign dmag  = d[VAL_W] ? (VAL_W+1)'(-d) : (VAL_W+1)'(d);
  assign r2    = {rem_r, 1'b0};
  assign r2sub = r2 - {1'b0, div_r};
  assign ge    = (r2 >= {1'b0, div_r});
  assign sh    = prod_r >>> FRACTION_BITS;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    t_nxt    = t_r;
    dy_nxt   = dy_r;
    y0_nxt   = y0_r;
    prod_nxt = prod_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          dy_nxt = {y1[VAL_W-1], y1} - {y0[VAL_W-1], y0};
          y0_nxt = y0;
          if (w == '0 || d == '0 || w[VAL_W] != d[VAL_W]) begin
            t_nxt  = '0;
            st_nxt = L_MUL;
          end else if (dmag >= wmag) begin
            t_nxt  = {1'b1, {FRACTION_BITS{1'b0}}};
            st_nxt = L_MUL;
          end else begin
            rem_nxt = dmag;
            div_nxt = wmag;
            t_nxt   = '0;
            cnt_nxt = '0;
            st_nxt  = L_DIV;
          end
        end
      end
      L_DIV: begin
        rem_nxt = ge ? r2sub[VAL_W:0] : r2[VAL_W:0];
        t_nxt   = {1'b0, t_r[FRACTION_BITS-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(FRACTION_BITS - 1)) st_nxt = L_MUL;
      end
      L_MUL: begin
        prod_nxt = dy_r * $signed({1'b0, t_r});
        st_nxt   = L_ADD;
      end
      L_ADD: begin
        res_nxt  = y0_r + sh[VAL_W-1:0];
        done_nxt = 1'b1;
        st_nxt   = L_IDLE;
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    t_r    <= t_nxt;
    dy_r   <= dy_nxt;
    y0_r   <= y0_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// File: rtl/bgi_back.sv
module bgi_back #(
  parameter int MAX_MONEYNESS_POINTS = 64,
  parameter int MAX_MATURITY_POINTS  = 64,
  parameter int FRACTION_BITS        = 20,
  localparam int CMW = $clog2(MAX_MONEYNESS_POINTS + 1),
  localparam int CTW = $clog2(MAX_MATURITY_POINTS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bgi_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_pop,
  input  logic [CMW-1:0] nm,
  input  logic [CTW-1:0] nt,
  bgi_out_if.source      out_ch
);
  import bgi_pkg::*;

  localparam int AMW = $clog2(MAX_MONEYNESS_POINTS);
  localparam int ATW = $clog2(MAX_MATURITY_POINTS);
  localparam int AVW = $clog2(MAX_MONEYNESS_POINTS * MAX_MATURITY_POINTS);
  localparam int RW  = ATW + CMW;

  logic signed [VAL_W-1:0] m_mem [MAX_MONEYNESS_POINTS];
  logic signed [VAL_W-1:0] t_mem [MAX_MATURITY_POINTS];
  logic signed [VAL_W-1:0] v_mem [MAX_MONEYNESS_POINTS * MAX_MATURITY_POINTS];
  logic signed [VAL_W-1:0] m_q, t_q, v_q;
  logic [AMW-1:0]          m_raddr;
  logic [ATW-1:0]          t_raddr;
  logic [AVW-1:0]          v_raddr;
  logic                    m_we, t_we, v_we;

  back_state_t             state_r, state_nxt;
  logic signed [VAL_W-1:0] qm_r, qm_nxt, qt_r, qt_nxt;
  logic signed [VAL_W-1:0] mfirst_r, mfirst_nxt, tfirst_r, tfirst_nxt;
  logic signed [VAL_W-1:0] m0_r, m0_nxt, m1_r, m1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [AMW-1:0]          mlo_r, mlo_nxt, mhi_r, mhi_nxt;
  logic [ATW-1:0]          tlo_r, tlo_nxt, thi_r, thi_nxt;
  logic [AVW-1:0]          row_r, row_nxt;
  logic [2:0]              vcnt_r, vcnt_nxt;
  logic signed [VAL_W-1:0] v_r [4];
  logic signed [VAL_W-1:0] v_nxt [4];
  logic [1:0]              lsel_r, lsel_nxt;
  logic signed [VAL_W-1:0] va_r, va_nxt, vb_r, vb_nxt, res_r, res_nxt;
  logic                    oor_r, oor_nxt;
  logic                    out_valid_r, out_valid_nxt, out_oor_r, out_oor_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;

  logic [AMW-1:0]          nm_last, m_mid;
  logic [ATW-1:0]          nt_last, t_mid;
  logic [AMW:0]            m_sum;
  logic [ATW:0]            t_sum;
  logic                    m_done, t_done;
  logic                    lerp_start, lerp_done;
  logic signed [VAL_W-1:0] l_x0, l_x1, l_x, l_y0, l_y1, lres;

  assign nm_last = AMW'(nm - CMW'(1));
  assign nt_last = ATW'(nt - CTW'(1));
  assign m_sum   = {1'b0, mlo_r} + {1'b0, mhi_r};
  assign t_sum   = {1'b0, tlo_r} + {1'b0, thi_r};
  assign m_mid   = m_sum[AMW:1];
  assign t_mid   = t_sum[ATW:1];
  assign m_done  = ((mhi_r - mlo_r) <= AMW'(1));
  assign t_done  = ((thi_r - tlo_r) <= ATW'(1));

  always_ff @(posedge clk) begin
    if (m_we) m_mem[AMW'(item.index)] <= item.value;
    m_q <= m_mem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) t_mem[ATW'(item.index)] <= item.value;
    t_q <= t_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) v_mem[AVW'(item.index)] <= item.value;
    v_q <= v_mem[v_raddr];
  end

  always_comb begin
    case (lsel_r)
      2'd0: begin
        l_x0 = m0_r; l_x1 = m1_r; l_x = qm_r; l_y0 = v_r[0]; l_y1 = v_r[1];
      end
      2'd1: begin
        l_x0 = m0_r; l_x1 = m1_r; l_x = qm_r; l_y0 = v_r[2]; l_y1 = v_r[3];
      end
      default: begin
        l_x0 = t0_r; l_x1 = t1_r; l_x = qt_r; l_y0 = va_r; l_y1 = vb_r;
      end
    endcase
  end

  bgi_lerp #(.FRACTION_BITS(FRACTION_BITS)) u_lerp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lerp_start),
    .x0     (l_x0),
    .x1     (l_x1),
    .x      (l_x),
    .y0     (l_y0),
    .y1     (l_y1),
    .done   (lerp_done),
    .result (lres)
  );

  always_comb begin
    state_nxt     = state_r;
    qm_nxt        = qm_r;
    qt_nxt        = qt_r;
    mfirst_nxt    = mfirst_r;
    tfirst_nxt    = tfirst_r;
    m0_nxt        = m0_r;
    m1_nxt        = m1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    mlo_nxt       = mlo_r;
    mhi_nxt       = mhi_r;
    tlo_nxt       = tlo_r;
    thi_nxt       = thi_r;
    row_nxt       = row_r;
    vcnt_nxt      = vcnt_r;
    v_nxt         = v_r;
    lsel_nxt      = lsel_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    res_nxt       = res_r;
    oor_nxt       = oor_r;
    out_val_nxt   = out_val_r;
    out_oor_nxt   = out_oor_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    m_raddr       = '0;
    t_raddr       = '0;
    v_raddr       = '0;
    m_we          = 1'b0;
    t_we          = 1'b0;
    v_we          = 1'b0;
    item_pop      = 1'b0;
    lerp_start    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          case (item.op)
            OP_LOAD_M: m_we = 1'b1;
            OP_LOAD_T: t_we = 1'b1;
            OP_LOAD_V: v_we = 1'b1;
            OP_QUERY: begin
              qm_nxt    = item.qm;
              qt_nxt    = item.qt;
              state_nxt = S_END0;
            end
            default: ;
          endcase
        end
      end
      S_END0: begin
        mfirst_nxt = m_q;
        tfirst_nxt = t_q;
        m_raddr    = nm_last;
        t_raddr    = nt_last;
        state_nxt  = S_END1;
      end
      S_END1: begin
        if (qm_r < mfirst_r || qm_r > m_q || qt_r < tfirst_r || qt_r > t_q) begin
          res_nxt   = '0;
          oor_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          oor_nxt = 1'b0;
          if (qm_r <= mfirst_r) begin
            mlo_nxt = '0;
            mhi_nxt = AMW'(1);
          end else if (qm_r >= m_q) begin
            mlo_nxt = nm_last - AMW'(1);
            mhi_nxt = nm_last;
          end else begin
            mlo_nxt = '0;
            mhi_nxt = nm_last;
          end
          if (qt_r <= tfirst_r) begin
            tlo_nxt = '0;
            thi_nxt = ATW'(1);
          end else if (qt_r >= t_q) begin
            tlo_nxt = nt_last - ATW'(1);
            thi_nxt = nt_last;
          end else begin
            tlo_nxt = '0;
            thi_nxt = nt_last;
          end
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (m_done && t_done) begin
          m_raddr   = mlo_r;
          t_raddr   = tlo_r;
          state_nxt = S_BRD0;
        end else begin
          m_raddr   = m_mid;
          t_raddr   = t_mid;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!m_done) begin
          if (qm_r < m_q) mhi_nxt = m_mid;
          else mlo_nxt = m_mid;
        end
        if (!t_done) begin
          if (qt_r < t_q) thi_nxt = t_mid;
          else tlo_nxt = t_mid;
        end
        state_nxt = S_SRD;
      end
      S_BRD0: begin
        m0_nxt    = m_q;
        t0_nxt    = t_q;
        m_raddr   = mlo_r + AMW'(1);
        t_raddr   = tlo_r + ATW'(1);
        state_nxt = S_BRD1;
      end
      S_BRD1: begin
        m1_nxt    = m_q;
        t1_nxt    = t_q;
        row_nxt   = AVW'(RW'(tlo_r) * RW'(nm));
        vcnt_nxt  = '0;
        state_nxt = S_VRD;
      end
      S_VRD: begin
        v_raddr = AVW'(row_r + AVW'(mlo_r) + (vcnt_r[1] ? AVW'(nm) : AVW'(0))
                       + AVW'(vcnt_r[0]));
        if (vcnt_r != 3'd0) v_nxt[2'(vcnt_r - 3'd1)] = v_q;
        if (vcnt_r == 3'd4) begin
          lsel_nxt  = 2'd0;
          state_nxt = S_LSTART;
        end else begin
          vcnt_nxt = vcnt_r + 3'd1;
        end
      end
      S_LSTART: begin
        lerp_start = 1'b1;
        state_nxt  = S_LWAIT;
      end
      S_LWAIT: begin
        if (lerp_done) begin
          case (lsel_r)
            2'd0: begin
              va_nxt    = lres;
              lsel_nxt  = 2'd1;
              state_nxt = S_LSTART;
            end
            2'd1: begin
              vb_nxt    = lres;
              lsel_nxt  = 2'd2;
              state_nxt = S_LSTART;
            end
            default: begin
              res_nxt   = lres;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_oor_nxt   = oor_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    qm_r      <= qm_nxt;
    qt_r      <= qt_nxt;
    mfirst_r  <= mfirst_nxt;
    tfirst_r  <= tfirst_nxt;
    m0_r      <= m0_nxt;
    m1_r      <= m1_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    mlo_r     <= mlo_nxt;
    mhi_r     <= mhi_nxt;
    tlo_r     <= tlo_nxt;
    thi_r     <= thi_nxt;
    row_r     <= row_nxt;
    vcnt_r    <= vcnt_nxt;
    v_r       <= v_nxt;
    lsel_r    <= lsel_nxt;
    va_r      <= va_nxt;
    vb_r      <= vb_nxt;
    res_r     <= res_nxt;
    oor_r     <= oor_nxt;
    out_val_r <= out_val_nxt;
    out_oor_r <= out_oor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.interpolated = out_val_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

// File: rtl/bilinear_grid_interpolator.sv
// Bilinear interpolation over a non-uniform 2D grid, signed fixed point.
// in_ch carries loads (moneyness axis, maturity axis, table value) and
// queries, selected by mode; loads with an index past the store are dropped.
// out_ch returns one result per query, none per load. cfg_ch writes the
// point counts (index 0 moneyness, 1 maturity); the user must write them only
// while the block is idle, as the block itself does not enforce it.
// A two-entry queue sits behind in_ch, so up to two items are taken while the
// back end is busy or out_ch is stalled; a finished result waits in the output
// register while the next item starts.
// Loads retire one per cycle while no query is in progress. A query runs a
// binary search over both axes (a registered axis read, then a compare, per
// step), four table reads, and three linear steps sharing one divider that
// produces one fraction bit per cycle. Out-of-span queries finish after the
// end-point reads.
// Reset clears the queue, the sequencer and the output valid, and sets both
// point counts to 2. Axis and table contents are undefined until loaded.
module bilinear_grid_interpolator #(
  parameter int MAX_MONEYNESS_POINTS = 64,
  parameter int MAX_MATURITY_POINTS  = 64,
  parameter int FRACTION_BITS        = 20
) (
  input logic       clk,
  input logic       rst_n,
  bgi_in_if.sink    in_ch,
  bgi_out_if.source out_ch,
  bgi_cfg_if.sink   cfg_ch
);
  import bgi_pkg::*;

  localparam int CMW = $clog2(MAX_MONEYNESS_POINTS + 1);
  localparam int CTW = $clog2(MAX_MATURITY_POINTS + 1);

  logic [PTS_W-1:0] mp_r, tp_r;
  logic [CMW-1:0]   nm;
  logic [CTW-1:0]   nt;
  item_t            item;
  logic             item_valid, item_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r <= PTS_W'(2);
      tp_r <= PTS_W'(2);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_MONEYNESS_POINTS) mp_r <= cfg_ch.data;
      if (cfg_ch.index == CFG_MATURITY_POINTS) tp_r <= cfg_ch.data;
    end
  end

  assign nm = (mp_r < PTS_W'(2)) ? CMW'(2) :
              (int'(mp_r) > MAX_MONEYNESS_POINTS) ? CMW'(MAX_MONEYNESS_POINTS) : CMW'(mp_r);
  assign nt = (tp_r < PTS_W'(2)) ? CTW'(2) :
              (int'(tp_r) > MAX_MATURITY_POINTS) ? CTW'(MAX_MATURITY_POINTS) : CTW'(tp_r);

  bgi_front #(
    .MAX_MONEYNESS_POINTS (MAX_MONEYNESS_POINTS),
    .MAX_MATURITY_POINTS  (MAX_MATURITY_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  bgi_back #(
    .MAX_MONEYNESS_POINTS (MAX_MONEYNESS_POINTS),
    .MAX_MATURITY_POINTS  (MAX_MATURITY_POINTS),
    .FRACTION_BITS        (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .nm         (nm),
    .nt         (nt),
    .out_ch     (out_ch)
  );

endmodule
